FILE: src/pds_pkg.sv
// pds_pkg: shared types, constants and the byte-step divide function for the
// pll divider search block. No dependencies.
`default_nettype none

package pds_pkg;

  localparam int unsigned PMax      = 128;
  localparam int unsigned KCount    = PMax / 2;
  localparam int unsigned KW        = $clog2(KCount);
  localparam int unsigned DivBits   = 8;
  localparam int unsigned DivWidth  = 32;
  localparam int unsigned DivStages = DivWidth / DivBits;
  localparam int unsigned DvsW      = 7;

  localparam logic [31:0] QStepHz = 32'd240000000;
  localparam logic [4:0]  QBelow  = 5'd2;
  localparam logic [4:0]  QSat    = 5'd31;

  localparam logic [31:0] RstVinMin  = 32'd1000000;
  localparam logic [31:0] RstVinMax  = 32'd16000000;
  localparam logic [31:0] RstVoutMin = 32'd150000000;
  localparam logic [31:0] RstVoutMax = 32'd960000000;
  localparam logic [31:0] RstOutLim  = 32'd480000000;
  localparam logic [5:0]  RstMUpper  = 6'd63;
  localparam logic [9:0]  RstNLower  = 10'd4;
  localparam logic [9:0]  RstNUpper  = 10'd512;

  localparam logic [3:0] CfgVinMin  = 4'd0;
  localparam logic [3:0] CfgVinMax  = 4'd1;
  localparam logic [3:0] CfgVoutMin = 4'd2;
  localparam logic [3:0] CfgVoutMax = 4'd3;
  localparam logic [3:0] CfgOutLim  = 4'd4;
  localparam logic [3:0] CfgMUpper  = 4'd5;
  localparam logic [3:0] CfgNLower  = 4'd6;
  localparam logic [3:0] CfgNUpper  = 4'd7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOFIT   = 2'd2
  } status_e;

  typedef struct packed {
    logic [5:0]  m;
    logic [9:0]  n;
    logic [7:0]  p;
    logic [31:0] vco;
  } cand_tag_t;

  typedef struct packed {
    logic load;
    logic div_ref;
    logic n_init;
    logic mul;
    logic p_issue;
    logic n_next;
    logic m_next;
    logic q_init;
    logic q_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad_input;
    logic m_none;
    logic m_last;
    logic ref_done;
    logic vin_ok;
    logic n_none;
    logic n_last;
    logic vco_ok;
    logic k_last;
    logic exact;
    logic pipe_empty;
    logic q_done;
  } sts_t;

  // eight restoring steps: returns {remainder, quotient byte}
  function automatic logic [DvsW+DivBits-1:0] div_byte(input logic [DvsW-1:0] rem,
                                                        input logic [DivBits-1:0] bits,
                                                        input logic [DvsW-1:0] dvs);
    logic [DvsW:0]      r;
    logic [DivBits-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = DivBits - 1; i >= 0; i--) begin
      r = {r[DvsW-1:0], bits[i]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return {r[DvsW-1:0], q};
  endfunction

endpackage

`default_nettype wire

FILE: src/pds_div.sv
// pds_div: pipelined 32-bit by 7-bit unsigned divider, one byte per stage.
// Depends on pds_pkg.
`default_nettype none

module pds_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_cand_i,
  input  wire logic [31:0]           in_num_i,
  input  wire logic [6:0]            in_dvs_i,
  input  wire pds_pkg::cand_tag_t    in_tag_i,
  output logic                       out_valid_o,
  output logic                       out_cand_o,
  output logic [31:0]                out_quo_o,
  output pds_pkg::cand_tag_t         out_tag_o,
  output logic                       busy_o
);

  typedef struct packed {
    logic                            cand;
    logic [pds_pkg::DivWidth-1:0]    num;
    logic [pds_pkg::DivWidth-1:0]    quo;
    logic [pds_pkg::DvsW-1:0]        rem;
    logic [pds_pkg::DvsW-1:0]        dvs;
    pds_pkg::cand_tag_t              tag;
  } stage_t;

  stage_t                          stg_q [pds_pkg::DivStages];
  stage_t                          stg_d [pds_pkg::DivStages];
  logic [pds_pkg::DivStages-1:0]   vld_q;

  always_comb begin
    stage_t                                    src;
    logic [pds_pkg::DvsW+pds_pkg::DivBits-1:0] step;
    for (int s = 0; s < pds_pkg::DivStages; s++) begin
      if (s == 0) begin
        src.cand = in_cand_i;
        src.num  = in_num_i;
        src.quo  = '0;
        src.rem  = '0;
        src.dvs  = in_dvs_i;
        src.tag  = in_tag_i;
      end else begin
        src = stg_q[s-1];
      end
      step = pds_pkg::div_byte(src.rem,
                               src.num[pds_pkg::DivWidth-1 -: pds_pkg::DivBits], src.dvs);
      stg_d[s]     = src;
      stg_d[s].num = src.num << pds_pkg::DivBits;
      stg_d[s].quo = {src.quo[pds_pkg::DivWidth-pds_pkg::DivBits-1:0],
                      step[pds_pkg::DivBits-1:0]};
      stg_d[s].rem = step[pds_pkg::DvsW+pds_pkg::DivBits-1:pds_pkg::DivBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[pds_pkg::DivStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < pds_pkg::DivStages; s++) begin
      stg_q[s] <= stg_d[s];
    end
  end

  assign out_valid_o = vld_q[pds_pkg::DivStages-1];
  assign out_cand_o  = stg_q[pds_pkg::DivStages-1].cand;
  assign out_quo_o   = stg_q[pds_pkg::DivStages-1].quo;
  assign out_tag_o   = stg_q[pds_pkg::DivStages-1].tag;
  assign busy_o      = |vld_q;

endmodule

`default_nettype wire

FILE: src/pds_datapath.sv
// pds_datapath: config registers, loop counters, candidate scoring, Q count
// and result registers. Depends on pds_pkg and pds_div.
`default_nettype none

module pds_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   ref_hz_i,
  input  wire logic [31:0]   want_hz_i,
  input  wire logic          cfg_we_i,
  input  wire logic [3:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire pds_pkg::cmd_t cmd_i,
  output pds_pkg::sts_t      sts_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [5:0]         div_m_o,
  output logic [9:0]         mul_n_o,
  output logic [7:0]         div_p_o,
  output logic [4:0]         div_q_o,
  output logic [7:0]         div_r_o
);

  logic [31:0] vin_min_q, vin_max_q, vout_min_q, vout_max_q, out_lim_q;
  logic [5:0]  m_upper_q;
  logic [9:0]  n_lower_q, n_upper_q;

  logic [31:0]            ref_q, want_q, vin_q;
  logic [5:0]             m_q;
  logic [9:0]             n_q;
  logic [pds_pkg::KW-1:0] k_q;
  logic [41:0]            prod_q;

  logic                   have_q, exact_q;
  logic [31:0]            best_err_q;
  pds_pkg::cand_tag_t     best_tag_q;

  logic                   e_valid_q, e_ok_q;
  logic [31:0]            e_err_q;
  pds_pkg::cand_tag_t     e_tag_q;

  logic [31:0]            qrem_q;
  logic [4:0]             qcnt_q;

  logic                   done_q;
  pds_pkg::status_e       res_status_q;
  logic [5:0]             res_m_q;
  logic [9:0]             res_n_q;
  logic [7:0]             res_p_q;
  logic [4:0]             res_q_q;

  logic                   dv_out_valid, dv_out_cand, dv_busy;
  logic [31:0]            dv_out_quo;
  pds_pkg::cand_tag_t     dv_out_tag;
  logic [31:0]            dv_num;
  logic [6:0]             dv_dvs;
  pds_pkg::cand_tag_t     dv_tag;
  logic [6:0]             k_val;
  logic [41:0]            prod_d;
  logic [32:0]            diff;
  logic [31:0]            err_d;
  logic                   take;
  logic                   bad_input;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_min_q  <= pds_pkg::RstVinMin;
      vin_max_q  <= pds_pkg::RstVinMax;
      vout_min_q <= pds_pkg::RstVoutMin;
      vout_max_q <= pds_pkg::RstVoutMax;
      out_lim_q  <= pds_pkg::RstOutLim;
      m_upper_q  <= pds_pkg::RstMUpper;
      n_lower_q  <= pds_pkg::RstNLower;
      n_upper_q  <= pds_pkg::RstNUpper;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pds_pkg::CfgVinMin:  vin_min_q  <= cfg_wdata_i;
        pds_pkg::CfgVinMax:  vin_max_q  <= cfg_wdata_i;
        pds_pkg::CfgVoutMin: vout_min_q <= cfg_wdata_i;
        pds_pkg::CfgVoutMax: vout_max_q <= cfg_wdata_i;
        pds_pkg::CfgOutLim:  out_lim_q  <= cfg_wdata_i;
        pds_pkg::CfgMUpper:  m_upper_q  <= cfg_wdata_i[5:0];
        pds_pkg::CfgNLower:  n_lower_q  <= cfg_wdata_i[9:0];
        pds_pkg::CfgNUpper:  n_upper_q  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // divider operands: ref / m, or candidate vco / (2 * k_val) == (vco >> 1) / k_val
  assign k_val  = {1'b0, k_q} + 7'd1;
  assign prod_d = vin_q * n_q;
  assign dv_num = cmd_i.div_ref ? ref_q : {1'b0, prod_q[31:1]};
  assign dv_dvs = cmd_i.div_ref ? {1'b0, m_q} : k_val;
  assign dv_tag = '{m: m_q, n: n_q, p: {k_val, 1'b0}, vco: prod_q[31:0]};

  pds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.div_ref | cmd_i.p_issue),
    .in_cand_i   (cmd_i.p_issue),
    .in_num_i    (dv_num),
    .in_dvs_i    (dv_dvs),
    .in_tag_i    (dv_tag),
    .out_valid_o (dv_out_valid),
    .out_cand_o  (dv_out_cand),
    .out_quo_o   (dv_out_quo),
    .out_tag_o   (dv_out_tag),
    .busy_o      (dv_busy)
  );

  assign diff  = {1'b0, dv_out_quo} - {1'b0, want_q};
  assign err_d = diff[32] ? (want_q - dv_out_quo) : diff[31:0];
  assign take  = e_valid_q && e_ok_q && !exact_q && (!have_q || (e_err_q < best_err_q));
  assign bad_input = (ref_q == '0) || (want_q == '0) || (want_q > out_lim_q);

  // loop counters and operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ref_q  <= ref_hz_i;
      want_q <= want_hz_i;
    end
    if (dv_out_valid && !dv_out_cand) begin
      vin_q <= dv_out_quo;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.n_init) begin
      n_q <= n_lower_q;
    end else if (cmd_i.n_next) begin
      n_q <= n_q + 10'd1;
    end
    if (cmd_i.load) begin
      m_q <= 6'd1;
    end else if (cmd_i.m_next) begin
      m_q <= m_q + 6'd1;
    end
    if (cmd_i.mul) begin
      k_q <= '0;
    end else if (cmd_i.p_issue) begin
      k_q <= k_q + 1'b1;
    end
  end

  // scoring stage and best candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      have_q    <= 1'b0;
      exact_q   <= 1'b0;
    end else begin
      e_valid_q <= dv_out_valid && dv_out_cand;
      if (cmd_i.load) begin
        have_q  <= 1'b0;
        exact_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
        if (e_err_q == '0) begin
          exact_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_err_q <= err_d;
    e_ok_q  <= dv_out_quo <= out_lim_q;
    e_tag_q <= dv_out_tag;
    if (take) begin
      best_err_q <= e_err_q;
      best_tag_q <= e_tag_q;
    end
    if (cmd_i.q_init) begin
      qrem_q <= have_q ? best_tag_q.vco : '0;
      qcnt_q <= '0;
    end else if (cmd_i.q_step) begin
      qrem_q <= qrem_q - pds_pkg::QStepHz;
      if (qcnt_q != pds_pkg::QSat) begin
        qcnt_q <= qcnt_q + 5'd1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (bad_input) begin
        res_status_q <= pds_pkg::ST_INVALID;
        res_m_q      <= '0;
        res_n_q      <= '0;
        res_p_q      <= '0;
        res_q_q      <= '0;
      end else if (!have_q) begin
        res_status_q <= pds_pkg::ST_NOFIT;
        res_m_q      <= '0;
        res_n_q      <= '0;
        res_p_q      <= '0;
        res_q_q      <= '0;
      end else begin
        res_status_q <= pds_pkg::ST_OK;
        res_m_q      <= best_tag_q.m;
        res_n_q      <= best_tag_q.n;
        res_p_q      <= best_tag_q.p;
        res_q_q      <= (qcnt_q == '0) ? pds_pkg::QBelow : qcnt_q;
      end
    end
  end

  assign sts_o.bad_input  = bad_input;
  assign sts_o.m_none     = (m_upper_q == '0);
  assign sts_o.m_last     = (m_q == m_upper_q);
  assign sts_o.ref_done   = dv_out_valid && !dv_out_cand;
  assign sts_o.vin_ok     = (vin_q >= vin_min_q) && (vin_q <= vin_max_q);
  assign sts_o.n_none     = (n_lower_q > n_upper_q);
  assign sts_o.n_last     = (n_q == n_upper_q);
  assign sts_o.vco_ok     = (prod_q[41:32] == '0) && (prod_q[31:0] >= vout_min_q) &&
                            (prod_q[31:0] <= vout_max_q);
  assign sts_o.k_last     = (k_q == '1);
  assign sts_o.exact      = exact_q;
  assign sts_o.pipe_empty = !dv_busy && !e_valid_q;
  assign sts_o.q_done     = (qrem_q < pds_pkg::QStepHz);

  assign done_o   = done_q;
  assign status_o = res_status_q;
  assign div_m_o  = res_m_q;
  assign mul_n_o  = res_n_q;
  assign div_p_o  = res_p_q;
  assign div_q_o  = res_q_q;
  assign div_r_o  = res_p_q;

  ap_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (res_status_q != pds_pkg::ST_OK) |->
      (res_m_q == '0) && (res_n_q == '0) && (res_p_q == '0) && (res_q_q == '0))
    else $error("failed result carries nonzero fields");

  ap_p_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (res_status_q == pds_pkg::ST_OK) |->
      (res_p_q != '0) && !res_p_q[0] && (res_m_q != '0))
    else $error("ok result with bad divider values");

  ap_exact_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exact_q |-> have_q)
    else $error("exact match flagged without a best candidate");

  ap_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

FILE: src/pds_ctrl.sv
// pds_ctrl: state machine that sequences the M, N and P loops, drain,
// Q count and result. Depends on pds_pkg.
`default_nettype none

module pds_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire pds_pkg::sts_t sts_i,
  output pds_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MDIV,
    S_MWAIT,
    S_MCHK,
    S_NMUL,
    S_NCHK,
    S_PRUN,
    S_NNEXT,
    S_MNEXT,
    S_DRAIN,
    S_QRUN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.bad_input) begin
          state_d = S_DONE;
        end else if (sts_i.m_none) begin
          state_d = S_DRAIN;
        end else begin
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd_o.div_ref = 1'b1;
        state_d       = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.ref_done) begin
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts_i.vin_ok && !sts_i.n_none) begin
          cmd_o.n_init = 1'b1;
          state_d      = S_NMUL;
        end else begin
          state_d = S_MNEXT;
        end
      end
      S_NMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_NCHK;
      end
      S_NCHK: begin
        state_d = sts_i.vco_ok ? S_PRUN : S_NNEXT;
      end
      S_PRUN: begin
        if (sts_i.exact) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.p_issue = 1'b1;
          if (sts_i.k_last) begin
            state_d = S_NNEXT;
          end
        end
      end
      S_NNEXT: begin
        if (sts_i.exact) begin
          state_d = S_DRAIN;
        end else if (sts_i.n_last) begin
          state_d = S_MNEXT;
        end else begin
          cmd_o.n_next = 1'b1;
          state_d      = S_NMUL;
        end
      end
      S_MNEXT: begin
        if (sts_i.exact || sts_i.m_last) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.m_next = 1'b1;
          state_d      = S_MDIV;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.q_init = 1'b1;
          state_d      = S_QRUN;
        end
      end
      S_QRUN: begin
        if (sts_i.q_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.q_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        busy_d       = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

  ap_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> sts_i.pipe_empty)
    else $error("divider pipeline busy while idle");

  ap_no_issue_after_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.p_issue |-> !sts_i.exact)
    else $error("candidate issued after exact match");

  ap_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != S_IDLE))
    else $error("busy out of step with state");

endmodule

`default_nettype wire

FILE: src/pll_divider_search_top.sv
// pll_divider_search_top: top level of the pll divider search block.
// Depends on pds_pkg, pds_ctrl, pds_datapath (and pds_div below it).
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  request   | start, busy            | ref_hz_i, want_hz_i
//  result    | done_o (one cycle)     | status_o, div_m_o, mul_n_o, div_p_o,
//            |                        | div_q_o, div_r_o
//  config    | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A request runs the M loop; for each M whose divided reference is in range, the N
// loop; and for each N whose VCO is in range, the P loop over every even P from 2 to
// 128; then drain, Q count and result. An invalid request goes straight to the result.
// The P loop feeds one candidate a cycle into a four-stage byte-serial divider. An
// exact match ends the search early. Reset needs no clearing pass; the receiver
// cannot stall results.
`default_nettype none

module pll_divider_search_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] ref_hz_i,
  input  wire logic [31:0] want_hz_i,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [5:0]       div_m_o,
  output logic [9:0]       mul_n_o,
  output logic [7:0]       div_p_o,
  output logic [4:0]       div_q_o,
  output logic [7:0]       div_r_o
);

  pds_pkg::cmd_t cmd;
  pds_pkg::sts_t sts;

  pds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pds_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ref_hz_i    (ref_hz_i),
    .want_hz_i   (want_hz_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .status_o    (status_o),
    .div_m_o     (div_m_o),
    .mul_n_o     (mul_n_o),
    .div_p_o     (div_p_o),
    .div_q_o     (div_q_o),
    .div_r_o     (div_r_o)
  );

endmodule

`default_nettype wire

FILE: dv/pll_divider_search_top_tb.sv
// testbench for pll_divider_search_top: directed and random searches checked
// against an in-bench model of the divider search. depends on pds_pkg and pll_divider_search_top.
module pll_divider_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 60_000_000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    pds_pkg::status_e st;
    logic [5:0]       m;
    logic [9:0]       n;
    logic [7:0]       p;
    logic [4:0]       q;
    logic [7:0]       r;
  } pll_plan_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] ref_hz_i;
  logic [31:0] want_hz_i;
  logic        cfg_we_i;
  logic [3:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [5:0]  div_m_o;
  logic [9:0]  mul_n_o;
  logic [7:0]  div_p_o;
  logic [4:0]  div_q_o;
  logic [7:0]  div_r_o;

  // register copies
  logic [31:0] vin_min_r, vin_max_r, vout_min_r, vout_max_r, out_lim_r;
  logic [5:0]  m_upper_r;
  logic [9:0]  n_lower_r, n_upper_r;

  pll_plan_t   pll_plans[$];
  pll_plan_t   want_plan, got_plan;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  pll_divider_search_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .ref_hz_i   (ref_hz_i),
    .want_hz_i  (want_hz_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .div_m_o    (div_m_o),
    .mul_n_o    (mul_n_o),
    .div_p_o    (div_p_o),
    .div_q_o    (div_q_o),
    .div_r_o    (div_r_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic pll_plan_t plan_pll(input logic [31:0] fref, input logic [31:0] fwant);
    pll_plan_t   res;
    logic [31:0] vin;
    logic [63:0] vout, sys, err, best_err, vco, qv;
    bit          have, exact;
    int unsigned m, n, p, bm, bn, bp;
    res = '0;
    have = 1'b0;
    exact = 1'b0;
    best_err = '0;
    bm = 0;
    bn = 0;
    bp = 0;
    if (fref == 0 || fwant == 0 || fwant > out_lim_r) begin
      res.st = pds_pkg::ST_INVALID;
      return res;
    end
    for (m = 1; m <= m_upper_r && !exact; m++) begin
      vin = fref / 32'(m);
      if (vin < vin_min_r || vin > vin_max_r) continue;
      for (n = n_lower_r; n <= n_upper_r && !exact; n++) begin
        vout = 64'(vin) * 64'(n);
        if (vout < 64'(vout_min_r) || vout > 64'(vout_max_r)) continue;
        for (p = 2; p <= pds_pkg::PMax; p += 2) begin
          sys = vout / 64'(p);
          if (sys > 64'(out_lim_r)) continue;
          err = (sys > 64'(fwant)) ? sys - 64'(fwant) : 64'(fwant) - sys;
          if (!have || err < best_err) begin
            have = 1'b1;
            best_err = err;
            bm = m;
            bn = n;
            bp = p;
          end
          if (err == 0) begin
            exact = 1'b1;
            break;
          end
        end
      end
    end
    if (!have) begin
      res.st = pds_pkg::ST_NOFIT;
      return res;
    end
    vco = 64'(fref / 32'(bm)) * 64'(bn);
    if (vco >= 64'(pds_pkg::QStepHz)) begin
      qv = vco / 64'(pds_pkg::QStepHz);
      if (qv > 64'(pds_pkg::QSat)) qv = 64'(pds_pkg::QSat);
    end else begin
      qv = 64'(pds_pkg::QBelow);
    end
    res.st = pds_pkg::ST_OK;
    res.m = bm[5:0];
    res.n = bn[9:0];
    res.p = bp[7:0];
    res.q = qv[4:0];
    res.r = bp[7:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_plan = {pds_pkg::status_e'(status_o), div_m_o, mul_n_o, div_p_o, div_q_o,
                  div_r_o};
      if (pll_plans.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: st=%0d m=%0d n=%0d p=%0d q=%0d r=%0d",
                   got_plan.st, got_plan.m, got_plan.n, got_plan.p, got_plan.q,
                   got_plan.r);
      end else begin
        want_plan = pll_plans.pop_front();
        if (got_plan.st !== want_plan.st || got_plan.m !== want_plan.m ||
            got_plan.n !== want_plan.n || got_plan.p !== want_plan.p ||
            got_plan.q !== want_plan.q || got_plan.r !== want_plan.r) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"mismatch: exp st=%0d m=%0d n=%0d p=%0d q=%0d r=%0d, ",
                      "got st=%0d m=%0d n=%0d p=%0d q=%0d r=%0d"},
                     want_plan.st, want_plan.m, want_plan.n, want_plan.p, want_plan.q,
                     want_plan.r, got_plan.st, got_plan.m, got_plan.n, got_plan.p,
                     got_plan.q, got_plan.r);
        end
      end
    end
  end

  task automatic request_search(input logic [31:0] fref, input logic [31:0] fwant);
    int unsigned gap;
    bit          taken;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    @(negedge clk_i);
    start     <= 1'b1;
    ref_hz_i  <= fref;
    want_hz_i <= fwant;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    pll_plans.push_back(plan_pll(fref, fwant));
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pll_plans.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pds_pkg::CfgVinMin:  vin_min_r = data;
      pds_pkg::CfgVinMax:  vin_max_r = data;
      pds_pkg::CfgVoutMin: vout_min_r = data;
      pds_pkg::CfgVoutMax: vout_max_r = data;
      pds_pkg::CfgOutLim:  out_lim_r = data;
      pds_pkg::CfgMUpper:  m_upper_r = data[5:0];
      pds_pkg::CfgNLower:  n_lower_r = data[9:0];
      pds_pkg::CfgNUpper:  n_upper_r = data[9:0];
      default: ;
    endcase
  endtask

  task automatic test_reset_values();
    request_search(32'd25_000_000, 32'd400_000_000);
    request_search(32'd0, 32'd100_000_000);
    request_search(32'd25_000_000, 32'd0);
    request_search(32'd25_000_000, 32'd480_000_001);
    request_search(32'd25_000_000, 32'd480_000_000);
    request_search(32'hFFFF_FFFF, 32'd1);
    request_search(32'd8_000_000, 32'd1);
    request_search(32'd1, 32'hFFFF_FFFF);
  endtask

  task automatic test_empty_search();
    wait_drain();
    write_reg(pds_pkg::CfgMUpper, 32'hFFFF_FFC0);
    request_search(32'd25_000_000, 32'd100_000_000);
    wait_drain();
    write_reg(pds_pkg::CfgMUpper, 32'h0000_003F);
    write_reg(pds_pkg::CfgNLower, 32'd300);
    write_reg(pds_pkg::CfgNUpper, 32'd200);
    request_search(32'd12_000_000, 32'd96_000_000);
    wait_drain();
    write_reg(pds_pkg::CfgNLower, 32'd4);
    write_reg(pds_pkg::CfgNUpper, 32'd512);
    write_reg(pds_pkg::CfgVinMin, 32'd16_000_001);
    request_search(32'd16_000_000, 32'd200_000_000);
  endtask

  task automatic test_zero_multiplier();
    wait_drain();
    write_reg(pds_pkg::CfgVinMin, 32'd0);
    write_reg(pds_pkg::CfgVinMax, 32'hFFFF_FFFF);
    write_reg(pds_pkg::CfgVoutMin, 32'd0);
    write_reg(pds_pkg::CfgVoutMax, 32'd0);
    write_reg(pds_pkg::CfgOutLim, 32'hFFFF_FFFF);
    write_reg(pds_pkg::CfgMUpper, 32'd1);
    write_reg(pds_pkg::CfgNLower, 32'hFFFF_FC00);
    write_reg(pds_pkg::CfgNUpper, 32'd3);
    // error of all ones must still be chosen
    request_search(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    request_search(32'd1, 32'd5);
  endtask

  task automatic test_large_q();
    wait_drain();
    write_reg(pds_pkg::CfgVinMin, 32'hFFFF_FFFF);
    write_reg(pds_pkg::CfgVoutMin, 32'hFFFF_0000);
    write_reg(pds_pkg::CfgVoutMax, 32'hFFFF_FFFF);
    write_reg(pds_pkg::CfgMUpper, 32'hFFFF_FFC1);
    write_reg(pds_pkg::CfgNLower, 32'hFFFF_FC01);
    write_reg(pds_pkg::CfgNUpper, 32'hFFFF_FFFF);
    write_reg(4'd15, 32'hFFFF_FFFF);
    request_search(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    request_search(32'h1234_5678, 32'h8000_0000);
  endtask

  task automatic test_random_phase(input int count);
    logic [31:0] lo_in, hi_in, lo_out, hi_out, lim, fref, fwant, vin0;
    logic [63:0] mid, tgt;
    int unsigned mu, nl, nu, m0, n0, p0, kind;
    wait_drain();
    mu = $urandom_range(1, 8);
    nl = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 200);
    nu = nl + $urandom_range(0, 48);
    lo_in = $urandom_range(0, 4_000_000);
    hi_in = lo_in + $urandom_range(500_000, 40_000_000);
    mid = 64'((lo_in + hi_in) / 2) * 64'((nl + nu) / 2 + 1);
    lo_out = (mid[63:33] != 0) ? $urandom : $urandom_range(0, 32'(mid >> 1));
    hi_out = (mid[63:31] != 0) ? 32'hFFFF_FFFF : 32'(mid << 1);
    lim = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom_range(1_000_000, 600_000_000);
    write_reg(pds_pkg::CfgVinMin, lo_in);
    write_reg(pds_pkg::CfgVinMax, hi_in);
    write_reg(pds_pkg::CfgVoutMin, lo_out);
    write_reg(pds_pkg::CfgVoutMax, hi_out);
    write_reg(pds_pkg::CfgOutLim, lim);
    write_reg(pds_pkg::CfgMUpper, ($urandom & ~32'h3F) | mu);
    write_reg(pds_pkg::CfgNLower, ($urandom & ~32'h3FF) | nl);
    write_reg(pds_pkg::CfgNUpper, ($urandom & ~32'h3FF) | nu);
    write_reg(4'($urandom_range(8, 15)), $urandom);
    repeat (count) begin
      kind = $urandom_range(0, 9);
      m0 = $urandom_range(1, mu);
      vin0 = $urandom_range(lo_in, hi_in);
      fref = vin0 * m0 + $urandom_range(0, m0 - 1);
      n0 = $urandom_range(nl, nu);
      p0 = 2 * $urandom_range(1, pds_pkg::PMax / 2);
      fwant = $urandom_range(1, lim);
      case (kind)
        0: begin
          fref = $urandom;
          fwant = $urandom;
        end
        1: begin
          case ($urandom_range(0, 2))
            0: fref = '0;
            1: fwant = '0;
            default: begin
              if (lim != 32'hFFFF_FFFF) fwant = lim + 1 + $urandom_range(0, 1000);
              else fref = '0;
            end
          endcase
        end
        2, 3, 4, 5: begin
          // aim at a reachable output so the search can end on a match
          tgt = (64'(vin0) * 64'(n0)) / 64'(p0);
          if (tgt == 0) tgt = 1;
          if (tgt > 64'(lim)) tgt = 64'(lim);
          fwant = tgt[31:0];
        end
        default: ;
      endcase
      request_search(fref, fwant);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    ref_hz_i    = '0;
    want_hz_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    vin_min_r   = pds_pkg::RstVinMin;
    vin_max_r   = pds_pkg::RstVinMax;
    vout_min_r  = pds_pkg::RstVoutMin;
    vout_max_r  = pds_pkg::RstVoutMax;
    out_lim_r   = pds_pkg::RstOutLim;
    m_upper_r   = pds_pkg::RstMUpper;
    n_lower_r   = pds_pkg::RstNLower;
    n_upper_r   = pds_pkg::RstNUpper;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_empty_search();
    test_zero_multiplier();
    test_large_q();
    for (int ph = 0; ph < 7; ph++) begin
      quiet = (ph >= 5);
      test_random_phase(12);
    end
    wait_drain();
    repeat (30) @(negedge clk_i);
    mismatches += pll_plans.size();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pds_pkg.sv
src/pds_div.sv
src/pds_datapath.sv
src/pds_ctrl.sv
src/pll_divider_search_top.sv
dv/pll_divider_search_top_tb.sv
